// ===== hw/rtl/nsd_pkg.sv =====
// Shared types, constants and binary32 helper functions for the Newton root block.
`default_nettype none
package nsd_pkg;

  localparam int DECIMALS_DEF = 2;

  localparam logic [31:0] F_INF = 32'h7F80_0000;
  localparam logic [31:0] F_TWO = 32'h4000_0000;
  localparam logic [31:0] F_TEN = 32'h4120_0000;
  localparam logic [31:0] F_LIM = 32'h4B00_0000;  // 8388608.0

  localparam logic [22:0] I24_MAX = 23'd8388607;
  localparam logic [22:0] RUP_LIM = 23'd8388597;  // above this, +10 saturates
  localparam logic [22:0] Q_SAT   = 23'd838860;   // I24_MAX / 10

  localparam logic [1:0] OP_DIV   = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_MUL10 = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic signed [10:0] e;  // biased exponent, may drop below 1
    logic [23:0]        m;  // leading one at bit 23
  } unp_t;

  function automatic unp_t unpack(input logic [31:0] f);
    unp_t       u;
    logic [4:0] lz;
    logic       found;
    lz    = 5'd0;
    found = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!found) begin
        if (f[i]) found = 1'b1;
        else lz = lz + 5'd1;
      end
    end
    if (f[30:23] == 8'd0) begin
      u.m = {1'b0, f[22:0]} << (lz + 5'd1);
      u.e = -$signed({6'd0, lz});
    end else begin
      u.m = {1'b1, f[22:0]};
      u.e = $signed({3'd0, f[30:23]});
    end
    return u;
  endfunction

  // sig: leading one at bit 26, three extra bits, st: sticky below them
  function automatic logic [31:0] round_pack(input logic signed [10:0] be,
                                             input logic [26:0] sig,
                                             input logic st);
    logic signed [10:0] shamt;
    logic [26:0]        s2;
    logic               st2;
    logic               inc;
    logic [24:0]        m25;
    logic [7:0]         ex;
    logic [31:0]        res;
    shamt = 11'sd1 - be;
    s2    = sig;
    st2   = st;
    if (be <= 11'sd0) begin
      if (shamt >= 11'sd27) begin
        s2  = 27'd0;
        st2 = st | (|sig);
      end else begin
        s2  = sig >> shamt[4:0];
        st2 = st | ((s2 << shamt[4:0]) != sig);
      end
    end
    inc = s2[2] & (s2[3] | s2[1] | s2[0] | st2);
    m25 = {1'b0, s2[26:3]} + {24'd0, inc};
    if (be >= 11'sd255) begin
      res = F_INF;
    end else if (be <= 11'sd0) begin
      res = {1'b0, 7'd0, m25[23], m25[22:0]};
    end else if (m25[24] && be == 11'sd254) begin
      res = F_INF;
    end else begin
      ex  = be[7:0] + {7'd0, m25[24]};
      res = {1'b0, ex, m25[22:0]};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/nsd_if.sv =====
// Valid/ready channel interfaces for the radicand input and the root result.
`default_nettype none
interface nsd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [4:0]  iterations;
  modport source (output valid, output value, output iterations, input ready);
  modport sink   (input valid, input value, input iterations, output ready);
endinterface

interface nsd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] root;
  logic        overflow;
  logic        invalid;
  modport source (output valid, output root, output overflow, output invalid, input ready);
  modport sink   (input valid, input root, input overflow, input invalid, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/newton_sqrt_decimal_round_top.sv =====
// Newton square root with decimal rounding: sequencer around the shared float unit.
// Result valid in the cycle after the input transfer for zero or invalid input; otherwise
//   after the halving, the Newton steps, the *10 scaling, rounding, normalisation and /10 divides.
// Each divide holds the sequencer until its 27-step restoring divide is done, an add or *10 until done.
// Throughput: one item at a time; input ready again the cycle after the result transfers.
// Reset: synchronous, active low; returns to idle, no result pending.
`default_nettype none
module newton_sqrt_decimal_round_top #(
  parameter int DECIMALS = nsd_pkg::DECIMALS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  nsd_in_if.sink     in_ch,
  nsd_out_if.source  out_ch
);
  import nsd_pkg::*;

  localparam int CW = $clog2(DECIMALS + 2);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HALF = 4'd1;   // wait value/2
  localparam logic [3:0] S_CHK  = 4'd2;   // next Newton step or leave
  localparam logic [3:0] S_Q    = 4'd3;   // wait value/ap
  localparam logic [3:0] S_SUM  = 4'd4;   // wait ap+q
  localparam logic [3:0] S_AVG  = 4'd5;   // wait sum/2
  localparam logic [3:0] S_RCHK = 4'd6;   // zero check before scaling
  localparam logic [3:0] S_MUL  = 4'd7;   // wait *10
  localparam logic [3:0] S_CONV = 4'd8;   // truncate to integer
  localparam logic [3:0] S_IDIV = 4'd9;   // integer /10 by reciprocal multiply
  localparam logic [3:0] S_RND  = 4'd10;  // round up on last digit
  localparam logic [3:0] S_NORM = 4'd11;  // integer to float, one shift a cycle
  localparam logic [3:0] S_DDIV = 4'd12;  // wait /10
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0]    state_r;
  logic [31:0]   v_r;
  logic [4:0]    it_r;
  logic [31:0]   ap_r;
  logic [31:0]   root_r;
  logic          ovf_r, inv_r;
  logic [CW-1:0] mcnt_r;
  logic [22:0]   num_r;
  logic [3:0]    irem_r;
  logic          big_r;
  logic [23:0]   nm_r;
  logic [7:0]    ne_r;
  logic          start_r;
  fpu_req_t      req_r;

  logic          fpu_done;
  logic [31:0]   fpu_res;

  logic [7:0]    cexp;
  logic [7:0]    csh;
  logic [23:0]   cmant;
  logic [22:0]   cnum;
  logic [46:0]   dprod;
  logic [22:0]   dq;
  logic [22:0]   drem;
  logic [22:0]   rq;
  logic [31:0]   nflt;

  nsd_fpu u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r),
    .req    (req_r),
    .done   (fpu_done),
    .result (fpu_res)
  );

  // truncation of the scaled value (only used when below 2^23)
  assign cexp  = ap_r[30:23];
  assign csh   = 8'd150 - cexp;
  assign cmant = {1'b1, ap_r[22:0]} >> csh[4:0];
  assign cnum  = (cexp < 8'd127) ? 23'd0 : cmant[22:0];

  // divide by ten: ceil(2^27/10) reciprocal, exact for operands below 2^26
  assign dprod = {24'd0, num_r} * {23'd0, 24'hCC_CCCD};
  assign dq    = {3'd0, dprod[46:27]};
  assign drem  = num_r - ((dq << 3) + (dq << 1));

  // quotient after the round-up decision
  always_comb begin
    rq = num_r;
    if (irem_r > 4'd4) begin
      if (big_r) rq = Q_SAT;
      else rq = num_r + 23'd1;
    end
  end

  assign nflt = {1'b0, ne_r, nm_r[22:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            ovf_r <= 1'b0;
            inv_r <= 1'b0;
            root_r <= 32'd0;
            v_r  <= in_ch.value;
            it_r <= in_ch.iterations;
            if (in_ch.value[30:0] == 31'd0) begin
              state_r <= S_OUT;
            end else if (in_ch.value[31] || in_ch.value[30:23] == 8'hFF) begin
              inv_r   <= 1'b1;
              state_r <= S_OUT;
            end else begin
              req_r   <= '{op: OP_DIV, a: in_ch.value, b: F_TWO};
              start_r <= 1'b1;
              state_r <= S_HALF;
            end
          end
        end
        S_HALF: begin
          if (fpu_done) begin
            ap_r    <= fpu_res;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (it_r == 5'd0) begin
            state_r <= S_RCHK;
          end else if (ap_r[30:0] == 31'd0) begin
            // division by a zero approximation gives +infinity
            ap_r <= F_INF;
            it_r <= it_r - 5'd1;
          end else begin
            req_r   <= '{op: OP_DIV, a: v_r, b: ap_r};
            start_r <= 1'b1;
            state_r <= S_Q;
          end
        end
        S_Q: begin
          if (fpu_done) begin
            req_r   <= '{op: OP_ADD, a: ap_r, b: fpu_res};
            start_r <= 1'b1;
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          if (fpu_done) begin
            req_r   <= '{op: OP_DIV, a: fpu_res, b: F_TWO};
            start_r <= 1'b1;
            state_r <= S_AVG;
          end
        end
        S_AVG: begin
          if (fpu_done) begin
            ap_r    <= fpu_res;
            it_r    <= it_r - 5'd1;
            state_r <= S_CHK;
          end
        end
        S_RCHK: begin
          if (ap_r[30:0] == 31'd0) begin
            state_r <= S_OUT;
          end else begin
            mcnt_r  <= '0;
            req_r   <= '{op: OP_MUL10, a: ap_r, b: 32'd0};
            start_r <= 1'b1;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (fpu_done) begin
            ap_r <= fpu_res;
            if (mcnt_r == CW'(DECIMALS)) begin
              state_r <= S_CONV;
            end else begin
              mcnt_r  <= mcnt_r + CW'(1);
              req_r   <= '{op: OP_MUL10, a: fpu_res, b: 32'd0};
              start_r <= 1'b1;
            end
          end
        end
        S_CONV: begin
          // positive float bit patterns compare like integers
          if (ap_r >= F_LIM) begin
            num_r <= I24_MAX;
            big_r <= 1'b1;
            ovf_r <= 1'b1;
          end else begin
            num_r <= cnum;
            big_r <= cnum > RUP_LIM;
          end
          state_r <= S_IDIV;
        end
        S_IDIV: begin
          num_r   <= dq;
          irem_r  <= drem[3:0];
          state_r <= S_RND;
        end
        S_RND: begin
          if (irem_r > 4'd4 && big_r) ovf_r <= 1'b1;
          nm_r <= {1'b0, rq};
          ne_r <= 8'd150;
          if (rq == 23'd0) state_r <= S_OUT;
          else state_r <= S_NORM;
        end
        S_NORM: begin
          if (nm_r[23]) begin
            mcnt_r <= '0;
            if (DECIMALS == 0) begin
              root_r  <= nflt;
              state_r <= S_OUT;
            end else begin
              req_r   <= '{op: OP_DIV, a: nflt, b: F_TEN};
              start_r <= 1'b1;
              state_r <= S_DDIV;
            end
          end else begin
            nm_r <= {nm_r[22:0], 1'b0};
            ne_r <= ne_r - 8'd1;
          end
        end
        S_DDIV: begin
          if (fpu_done) begin
            if (mcnt_r + CW'(1) == CW'(DECIMALS)) begin
              root_r  <= fpu_res;
              state_r <= S_OUT;
            end else begin
              mcnt_r  <= mcnt_r + CW'(1);
              req_r   <= '{op: OP_DIV, a: fpu_res, b: F_TEN};
              start_r <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_ch.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = (state_r == S_OUT);
  assign out_ch.root     = root_r;
  assign out_ch.overflow = ovf_r;
  assign out_ch.invalid  = inv_r;

endmodule
`default_nettype wire

// ===== hw/rtl/nsd_fpu.sv =====
// Shared binary32 unit: iterative divide, combinational add and multiply by ten with a registered result.
`default_nettype none
module nsd_fpu (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire nsd_pkg::fpu_req_t req,
  output logic                   done,
  output logic [31:0]            result
);
  import nsd_pkg::*;

  logic               busy_r, busy_nxt;
  logic               fin_r, fin_nxt;
  logic               done_r, done_nxt;
  logic [31:0]        res_r, res_nxt;
  logic [24:0]        rem_r, rem_nxt;
  logic [23:0]        mb_r, mb_nxt;
  logic [26:0]        quo_r, quo_nxt;
  logic signed [10:0] be_r, be_nxt;
  logic [4:0]         cnt_r, cnt_nxt;

  unp_t               ua, ub;
  logic               ge;
  logic [24:0]        diff;

  function automatic logic [31:0] add_f(input logic [31:0] a, input logic [31:0] b);
    unp_t        x, y, t;
    logic [10:0] d;
    logic [26:0] big, sm;
    logic        st;
    logic [27:0] sum;
    logic [31:0] r;
    x = unpack(a);
    y = unpack(b);
    if (y.e > x.e) begin
      t = x; x = y; y = t;
    end
    d   = 11'(x.e - y.e);
    big = {x.m, 3'b000};
    if (d >= 11'd27) begin
      sm = 27'd0;
      st = 1'b1;
    end else begin
      sm = {y.m, 3'b000} >> d[4:0];
      st = (sm << d[4:0]) != {y.m, 3'b000};
    end
    sum = {1'b0, big} + {1'b0, sm};
    if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) r = F_INF;
    else if (a[30:0] == 31'd0) r = b;
    else if (b[30:0] == 31'd0) r = a;
    else if (sum[27]) r = round_pack(x.e + 11'sd1, sum[27:1], st | sum[0]);
    else r = round_pack(x.e, sum[26:0], st);
    return r;
  endfunction

  function automatic logic [31:0] mul10_f(input logic [31:0] a);
    unp_t        x;
    logic [27:0] p;
    logic [31:0] r;
    x = unpack(a);
    p = {4'd0, x.m} * 28'd10;
    if (a[30:23] == 8'hFF) r = F_INF;
    else if (a[30:0] == 31'd0) r = 32'd0;
    else if (p[27]) r = round_pack(x.e + 11'sd4, p[27:1], p[0]);
    else r = round_pack(x.e + 11'sd3, p[26:0], 1'b0);
    return r;
  endfunction

  assign ua   = unpack(req.a);
  assign ub   = unpack(req.b);
  assign ge   = rem_r >= {1'b0, mb_r};
  assign diff = ge ? (rem_r - {1'b0, mb_r}) : rem_r;

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    rem_nxt  = rem_r;
    mb_nxt   = mb_r;
    quo_nxt  = quo_r;
    be_nxt   = be_r;
    cnt_nxt  = cnt_r;
    if (fin_r) begin
      res_nxt  = round_pack(be_r, quo_r, rem_r != 25'd0);
      done_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[25:0], ge};
      rem_nxt = {diff[23:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (start) begin
      unique case (req.op)
        OP_ADD: begin
          res_nxt  = add_f(req.a, req.b);
          done_nxt = 1'b1;
        end
        OP_MUL10: begin
          res_nxt  = mul10_f(req.a);
          done_nxt = 1'b1;
        end
        default: begin
          if (req.a[30:0] == 31'd0 || req.b[30:23] == 8'hFF) begin
            res_nxt  = 32'd0;
            done_nxt = 1'b1;
          end else if (req.a[30:23] == 8'hFF) begin
            res_nxt  = F_INF;
            done_nxt = 1'b1;
          end else begin
            mb_nxt   = ub.m;
            quo_nxt  = 27'd0;
            cnt_nxt  = 5'd26;
            busy_nxt = 1'b1;
            if (ua.m < ub.m) begin
              rem_nxt = {ua.m, 1'b0};
              be_nxt  = ua.e - ub.e + 11'sd126;
            end else begin
              rem_nxt = {1'b0, ua.m};
              be_nxt  = ua.e - ub.e + 11'sd127;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
    res_r <= res_nxt;
    rem_r <= rem_nxt;
    mb_r  <= mb_nxt;
    quo_r <= quo_nxt;
    be_r  <= be_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
`default_nettype wire
